// ===== hw/rtl/lphm_pkg.sv =====
package lphm_pkg;

  typedef enum logic [2:0] {
    FN_PUT   = 3'd0,
    FN_LOOK  = 3'd1,
    FN_CLEAR = 3'd2,
    FN_FIRST = 3'd3,
    FN_NEXT  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_NEW   = 3'd0,
    ST_HIT   = 3'd1,
    ST_END   = 3'd2,
    ST_FULL  = 3'd3,
    ST_ZERO  = 3'd4,
    ST_STALE = 3'd5,
    ST_WRAP  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_SCAN,
    S_CLEAR,
    S_OUT
  } state_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned CountW = 11;
  localparam logic [CountW-1:0] FillLimitRst = 11'd877;

endpackage

// ===== hw/rtl/lphm_ram.sv =====
module lphm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/linear_probe_hash_map.sv =====
// Channel | Direction | Signals
// input   | in        | in_valid_i, in_ready_o, func_i, key_i, value_i
// result  | out       | out_valid_o, out_ready_i, status_o, out_key_o, out_value_o, slot_o, count_o
// config  | in        | cfg_we_i, cfg_wdata_i
// Put and lookup hash the key to its home slot, then read slots until key, empty or wrap.
// Iterate first/next scan slots up to the next occupied one or the end of the table.
// Clear all zeroes the key RAM, one key RAM write a cycle.
// Zero key, unknown func and a stale or ended iterate next go straight to the result.
// After reset a clearing pass zeroes the key RAM; no beat is taken then.
// One item at a time; a result held on a stalled output blocks the next input beat.
module linear_probe_hash_map #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    func_i,
  input  logic [lphm_pkg::KeyW-1:0]     key_i,
  input  logic [lphm_pkg::ValW-1:0]     value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [lphm_pkg::KeyW-1:0]     out_key_o,
  output logic [lphm_pkg::ValW-1:0]     out_value_o,
  output logic [lphm_pkg::SlotW-1:0]    slot_o,
  output logic [lphm_pkg::CountW-1:0]   count_o,
  input  logic                          cfg_we_i,
  input  logic [lphm_pkg::CountW-1:0]   cfg_wdata_i
);
  import lphm_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned PrW = 2 * KeyW;
  localparam logic [AW-1:0] LastA = AW'(SLOTS - 1);
  localparam logic [PW-1:0] SlotsP = PW'(SLOTS);
  localparam longint unsigned RecipL = 64'h1_0000_0000 / 64'(SLOTS);
  localparam logic [KeyW-1:0] Recip = KeyW'(RecipL);

  state_e state_q, state_d;
  logic [2:0]  func_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [AW-1:0] pos_q, pos_d;
  logic [PW-1:0] n_q, n_d;
  logic rd_pend_q, rd_pend_d;
  logic [PW-1:0] fill_q, fill_d;
  logic [CountW-1:0] limit_q;
  logic [PW-1:0] iter_q, iter_d;
  logic done_q, done_d, stale_q, stale_d;
  logic init_q, init_d;
  logic [1:0] hstep_q, hstep_d;
  logic [KeyW-1:0] quot_q, quot_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [PrW-1:0] quot_prod;

  logic [2:0] st_q, st_d;
  logic [KeyW-1:0] ok_q, ok_d;
  logic [ValW-1:0] ov_q, ov_d;
  logic [AW-1:0] os_q, os_d;
  logic [PW-1:0] oc_q, oc_d;

  logic k_we, v_we;
  logic [AW-1:0] k_wa, raddr;
  logic [KeyW-1:0] k_wd, k_rd;
  logic [ValW-1:0] v_rd;

  logic [AW-1:0] home;
  logic in_fire;
  logic [PW-1:0] scan_start;

  // reciprocal estimate is low by at most one, so one subtract finishes the reduction
  assign quot_prod = PrW'(key_q) * PrW'(Recip);
  assign home = (rem_q >= SlotsP) ? AW'(rem_q - SlotsP) : AW'(rem_q);
  assign in_ready_o = (state_q == S_IDLE) && !init_q;
  assign in_fire = in_valid_i && in_ready_o;
  assign scan_start = (func_i == FN_FIRST) ? '0 : iter_q;

  lphm_ram #(.Width(KeyW), .Depth(SLOTS)) u_key_ram (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd),
    .raddr_i(raddr), .rdata_o(k_rd)
  );
  lphm_ram #(.Width(ValW), .Depth(SLOTS)) u_val_ram (
    .clk_i, .we_i(v_we), .waddr_i(pos_q), .wdata_i(val_q),
    .raddr_i(raddr), .rdata_o(v_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((func_i == FN_PUT || func_i == FN_LOOK) && key_i != '0) state_d = S_HASH;
          else if (func_i == FN_CLEAR) state_d = S_CLEAR;
          else if (func_i == FN_FIRST ||
                   (func_i == FN_NEXT && !stale_q && !done_q)) begin
            state_d = (scan_start >= SlotsP) ? S_OUT : S_SCAN;
          end else state_d = S_OUT;
        end
      end
      S_HASH: if (hstep_q == 2'd2) state_d = S_PROBE;
      S_PROBE: begin
        if (rd_pend_q && (k_rd == key_q || k_rd == '0)) state_d = S_OUT;
        else if (rd_pend_q && n_q == SlotsP - PW'(1)) state_d = S_OUT;
      end
      S_SCAN: begin
        if (rd_pend_q && (k_rd != '0 || n_q == SlotsP - PW'(1))) state_d = S_OUT;
      end
      S_CLEAR: if (pos_q == LastA) state_d = S_OUT;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pos_d = pos_q; n_d = n_q; rd_pend_d = 1'b0;
    fill_d = fill_q; iter_d = iter_q; done_d = done_q; stale_d = stale_q;
    init_d = init_q;
    hstep_d = '0; quot_d = quot_q; rem_d = rem_q;
    st_d = st_q; ok_d = ok_q; ov_d = ov_q; os_d = os_q; oc_d = oc_q;
    k_we = 1'b0; v_we = 1'b0; k_wa = pos_q; k_wd = '0; raddr = pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (init_q) begin
          k_we = 1'b1;
          pos_d = pos_q + AW'(1);
          if (pos_q == LastA) init_d = 1'b0;
        end else if (in_fire) begin
          st_d = ST_END; ok_d = '0; ov_d = '0; os_d = '0; oc_d = fill_q;
          n_d = '0;
          case (func_i)
            FN_PUT, FN_LOOK: begin
              if (key_i == '0) st_d = ST_ZERO;
            end
            FN_CLEAR: begin
              st_d = ST_HIT; pos_d = '0; fill_d = '0; stale_d = 1'b1;
            end
            FN_FIRST, FN_NEXT: begin
              if (func_i == FN_FIRST) stale_d = 1'b0;
              if (func_i == FN_NEXT && stale_q) st_d = ST_STALE;
              else if (func_i == FN_NEXT && done_q) st_d = ST_END;
              else if (scan_start >= SlotsP) begin
                iter_d = SlotsP; done_d = 1'b1;
              end else begin
                pos_d = AW'(scan_start); raddr = AW'(scan_start);
                rd_pend_d = 1'b1;
                n_d = scan_start;
              end
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        hstep_d = hstep_q + 2'd1;
        case (hstep_q)
          2'd0: quot_d = quot_prod[PrW-1:KeyW];
          2'd1: rem_d = PW'(key_q - quot_q * KeyW'(SLOTS));
          default: begin
            pos_d = home; raddr = home; rd_pend_d = 1'b1; n_d = '0;
          end
        endcase
      end
      S_PROBE: begin
        if (rd_pend_q) begin
          if (k_rd == key_q) begin
            st_d = ST_HIT; ok_d = key_q; ov_d = v_rd; os_d = pos_q;
            if (func_q == FN_PUT) begin
              v_we = 1'b1; stale_d = 1'b1;
            end
          end else if (k_rd == '0) begin
            if (func_q == FN_LOOK) st_d = ST_END;
            else if ({{CountW{1'b0}}, fill_q} >= {{PW{1'b0}}, limit_q}) st_d = ST_FULL;
            else begin
              k_we = 1'b1; k_wd = key_q; v_we = 1'b1;
              fill_d = fill_q + PW'(1); oc_d = fill_q + PW'(1);
              stale_d = 1'b1;
              st_d = ST_NEW; ok_d = key_q; os_d = pos_q;
            end
          end else if (n_q == SlotsP - PW'(1)) begin
            st_d = ST_WRAP;
          end else begin
            pos_d = (pos_q == LastA) ? '0 : pos_q + AW'(1);
            raddr = pos_d; rd_pend_d = 1'b1; n_d = n_q + PW'(1);
          end
        end
      end
      S_SCAN: begin
        if (rd_pend_q) begin
          if (k_rd != '0) begin
            st_d = ST_HIT; ok_d = k_rd; ov_d = v_rd; os_d = pos_q;
            iter_d = n_q + PW'(1); done_d = 1'b0;
          end else if (n_q == SlotsP - PW'(1)) begin
            iter_d = SlotsP; done_d = 1'b1;
          end else begin
            pos_d = pos_q + AW'(1); raddr = pos_d; rd_pend_d = 1'b1;
            n_d = n_q + PW'(1);
          end
        end
      end
      S_CLEAR: begin
        k_we = 1'b1;
        pos_d = pos_q + AW'(1);
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_pend_q <= 1'b0;
      fill_q <= '0;
      limit_q <= FillLimitRst;
      iter_q <= '0;
      done_q <= 1'b1;
      stale_q <= 1'b0;
      init_q <= 1'b1;
      pos_q <= '0;
      hstep_q <= '0;
    end else begin
      state_q <= state_d;
      rd_pend_q <= rd_pend_d;
      fill_q <= fill_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      iter_q <= iter_d;
      done_q <= done_d;
      stale_q <= stale_d;
      init_q <= init_d;
      pos_q <= pos_d;
      hstep_q <= hstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i; key_q <= key_i; val_q <= value_i;
    end
    n_q <= n_d;
    quot_q <= quot_d; rem_q <= rem_d;
    st_q <= st_d; ok_q <= ok_d; ov_q <= ov_d; os_q <= os_d; oc_q <= oc_d;
  end

  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = st_q;
  assign out_key_o   = ok_q;
  assign out_value_o = ov_q;
  assign slot_o      = SlotW'(os_q);
  assign count_o     = CountW'(oc_q);

endmodule

// ===== hw/rtl/lphm_checker.sv =====
module lphm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] out_key_o,
  input logic [10:0] count_o
);
  import lphm_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");

  a_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ZERO || status_o == ST_FULL || status_o == ST_WRAP)
    |-> out_key_o == '0) else $error("key on refusal");

  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NEW |-> count_o != '0) else $error("insert with zero fill");

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .out_key_o, .count_o
);

// ===== tb/tb_linear_probe_hash_map.sv =====
`timescale 1ns / 100ps

module tb_linear_probe_hash_map;
  import lphm_pkg::*;

  localparam int unsigned NSLOT = 1024;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [2:0]        status;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } map_reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        func_i = '0;
  logic [KeyW-1:0]   key_i = '0;
  logic [ValW-1:0]   value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        status_o;
  logic [KeyW-1:0]   out_key_o;
  logic [ValW-1:0]   out_value_o;
  logic [SlotW-1:0]  slot_o;
  logic [CountW-1:0] count_o;
  logic              cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;

  linear_probe_hash_map #(.SLOTS(NSLOT)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .key_i, .value_i,
    .out_valid_o, .out_ready_i, .status_o, .out_key_o, .out_value_o,
    .slot_o, .count_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // model of the table
  logic [KeyW-1:0]   mdl_keys [NSLOT];
  logic [ValW-1:0]   mdl_vals [NSLOT];
  int unsigned       mdl_fill;
  int unsigned       mdl_pos;
  bit                mdl_done;
  bit                mdl_stale;
  logic [CountW-1:0] mdl_limit;

  map_reply_t  expected_replies [$];
  int unsigned error_count;
  int unsigned reply_count;
  int unsigned cycle_count;
  bit          idle_enable = 1'b1;
  int unsigned func_seen [8];
  int unsigned stall_left;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (reply %0d)", what, got, want, reply_count);
    error_count++;
  endtask

  function automatic map_reply_t make_reply(logic [2:0] st, logic [KeyW-1:0] k,
                                            logic [ValW-1:0] v, int unsigned s,
                                            int unsigned c);
    map_reply_t r;
    r.status = st; r.key = k; r.value = v;
    r.slot = s[SlotW-1:0]; r.count = c[CountW-1:0];
    return r;
  endfunction

  // 0 hit, 1 empty, 2 wrapped
  function automatic int probe_table(logic [KeyW-1:0] k, output int unsigned pos);
    int unsigned i;
    i = k % NSLOT;
    pos = 0;
    for (int unsigned n = 0; n < NSLOT; n++) begin
      if (mdl_keys[i] == k) begin
        pos = i;
        return 0;
      end
      if (mdl_keys[i] == '0) begin
        pos = i;
        return 1;
      end
      i = (i + 1) % NSLOT;
    end
    return 2;
  endfunction

  function automatic map_reply_t scan_table();
    for (int unsigned h = mdl_pos; h < NSLOT; h++) begin
      if (mdl_keys[h] != '0) begin
        mdl_pos = h + 1;
        mdl_done = 1'b0;
        return make_reply(ST_HIT, mdl_keys[h], mdl_vals[h], h, mdl_fill);
      end
    end
    mdl_pos = NSLOT;
    mdl_done = 1'b1;
    return make_reply(ST_END, '0, '0, 0, mdl_fill);
  endfunction

  function automatic map_reply_t predict_reply(logic [2:0] fn, logic [KeyW-1:0] k,
                                               logic [ValW-1:0] v);
    int unsigned pos;
    int r;
    logic [ValW-1:0] old;
    int unsigned fill_prev;
    case (fn)
      FN_PUT, FN_LOOK: begin
        if (k == '0) return make_reply(ST_ZERO, '0, '0, 0, mdl_fill);
        r = probe_table(k, pos);
        if (r == 2) return make_reply(ST_WRAP, '0, '0, 0, mdl_fill);
        if (fn == FN_LOOK) begin
          if (r == 0) return make_reply(ST_HIT, k, mdl_vals[pos], pos, mdl_fill);
          return make_reply(ST_END, '0, '0, 0, mdl_fill);
        end
        if (r == 0) begin
          old = mdl_vals[pos];
          mdl_vals[pos] = v;
          mdl_stale = 1'b1;
          return make_reply(ST_HIT, k, old, pos, mdl_fill);
        end
        if (mdl_fill >= mdl_limit) return make_reply(ST_FULL, '0, '0, 0, mdl_fill);
        mdl_keys[pos] = k;
        mdl_vals[pos] = v;
        mdl_fill++;
        mdl_stale = 1'b1;
        return make_reply(ST_NEW, k, '0, pos, mdl_fill);
      end
      FN_CLEAR: begin
        fill_prev = mdl_fill;
        foreach (mdl_keys[i]) mdl_keys[i] = '0;
        mdl_fill = 0;
        mdl_stale = 1'b1;
        return make_reply(ST_HIT, '0, '0, 0, fill_prev);
      end
      FN_FIRST: begin
        mdl_stale = 1'b0;
        mdl_pos = 0;
        return scan_table();
      end
      FN_NEXT: begin
        if (mdl_stale) return make_reply(ST_STALE, '0, '0, 0, mdl_fill);
        if (mdl_done) return make_reply(ST_END, '0, '0, 0, mdl_fill);
        return scan_table();
      end
      default: return make_reply(ST_END, '0, '0, 0, mdl_fill);
    endcase
  endfunction

  task automatic random_gap();
    if (idle_enable && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
  endtask

  task automatic send_item(input logic [2:0] fn, input logic [KeyW-1:0] k,
                           input logic [ValW-1:0] v);
    random_gap();
    func_i <= fn; key_i <= k; value_i <= v; in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_replies.push_back(predict_reply(fn, k, v));
    func_seen[fn]++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // the block cannot take a beat the cycle after one, so nothing is lost here
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_replies.size() != 0) @(negedge clk_i);
    repeat (NSLOT + 20) @(negedge clk_i);
  endtask

  task automatic write_limit(input int unsigned lim);
    wait_drained();
    cfg_we_i <= 1'b1; cfg_wdata_i <= lim[CountW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_limit = lim[CountW-1:0];
  endtask

  // random result stall bursts while idle_enable is set
  always @(negedge clk_i) begin
    if (!idle_enable) out_ready_i <= 1'b1;
    else if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 12);
    end else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    map_reply_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply", status_o, 0);
      end else begin
        want = expected_replies.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (out_key_o !== want.key) report_mismatch("key", out_key_o, want.key);
        if (out_value_o !== want.value) report_mismatch("value", out_value_o, want.value);
        if (slot_o !== want.slot) report_mismatch("slot", slot_o, want.slot);
        if (count_o !== want.count) report_mismatch("count", count_o, want.count);
      end
      reply_count++;
    end
  end

  function automatic logic [KeyW-1:0] pick_key(int unsigned pool);
    // half the keys are multiples of NSLOT plus 1 to 4, so their probes collide
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(1, pool);
      default: return ($urandom_range(0, 7) * NSLOT) + $urandom_range(1, 4);
    endcase
  endfunction

  task automatic test_directed();
    send_item(FN_NEXT, '0, '0);
    send_item(FN_FIRST, '0, '0);
    send_item(FN_PUT, '0, 32'hFFFF_FFFF);
    send_item(FN_LOOK, '0, '0);
    send_item(FN_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_PUT, 32'h0000_0400, 32'h1234_5678);
    send_item(FN_PUT, 32'h0000_0800, '0);
    send_item(FN_PUT, 32'h0000_03FF, 32'hA5A5_5A5A);
    send_item(FN_PUT, 32'h0000_07FF, 32'h5A5A_A5A5);
    send_item(FN_PUT, 32'h0000_0400, 32'hDEAD_BEEF);
    send_item(FN_LOOK, 32'h0000_0800, '0);
    send_item(FN_LOOK, 32'h0000_0C00, '0);
    send_item(FN_FIRST, '0, '0);
    send_item(FN_NEXT, '0, '0);
    send_item(FN_PUT, 32'h0000_0001, 32'h1);
    send_item(FN_NEXT, '0, '0);
    send_item(FN_FIRST, '0, '0);
    repeat (6) send_item(FN_NEXT, '0, '0);
    for (int f = 5; f < 8; f++) send_item(f[2:0], $urandom(), $urandom());
    send_item(FN_CLEAR, '0, '0);
    send_item(FN_NEXT, '0, '0);
  endtask

  task automatic test_fill_limits();
    write_limit(0);
    send_item(FN_PUT, 32'h55, 32'h1);
    write_limit(2);
    repeat (4) send_item(FN_PUT, pick_key(20), $urandom());
    send_item(FN_CLEAR, '0, '0);
    write_limit(1024);
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      if (i == n - n / 5) idle_enable = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 45) send_item(FN_PUT, pick_key(64), $urandom());
      else if (pick < 70) send_item(FN_LOOK, pick_key(64), '0);
      else if (pick < 73) send_item(FN_CLEAR, '0, '0);
      else if (pick < 78) send_item(FN_FIRST, '0, '0);
      else if (pick < 96) send_item(FN_NEXT, '0, '0);
      else send_item(3'($urandom_range(0, 7)), $urandom(), $urandom());
      if (i == n / 3) write_limit($urandom_range(8, 200));
    end
  endtask

  initial begin
    foreach (mdl_keys[i]) begin
      mdl_keys[i] = '0;
      mdl_vals[i] = '0;
    end
    mdl_fill = 0; mdl_pos = 0; mdl_done = 1'b1; mdl_stale = 1'b0;
    mdl_limit = FillLimitRst;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_limits();
    test_random(800);
    wait_drained();
    $display("covered %0d replies: put %0d lookup %0d clear %0d first %0d next %0d",
             reply_count, func_seen[0], func_seen[1], func_seen[2], func_seen[3],
             func_seen[4]);
    $display("fill limits 0, 2, 1024 and a random one; stale and ended iteration");
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("errors %0d, left over %0d", error_count, expected_replies.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
